### src/scba_pkg.sv
package scba_pkg;

    // field widths
    localparam int ADDR_W = 17;
    localparam int SIZE_W = 16;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;

    // size class limits in bytes
    localparam logic [SIZE_W-1:0] CLASS0_BYTES = 16'd32;
    localparam logic [SIZE_W-1:0] CLASS1_BYTES = 16'd64;
    localparam logic [SIZE_W-1:0] CLASS2_BYTES = 16'd128;
    localparam logic [SIZE_W-1:0] CLASS3_BYTES = 16'd256;

    // pool codes
    localparam logic [1:0] POOL_32  = 2'd0;
    localparam logic [1:0] POOL_64  = 2'd1;
    localparam logic [1:0] POOL_128 = 2'd2;
    localparam logic [1:0] POOL_256 = 2'd3;

    // result codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FREE   = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_POOL_FULL = 3'd3,
        ST_BAD_ADDR  = 3'd4
    } status_t;

    // command codes
    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_INIT,
        BK_IDLE,
        BK_POP
    } bk_state_t;

    // classified request, front to back
    typedef struct packed {
        cmd_t             op;
        status_t          err;
        logic [1:0]       pool;
        logic [IDX_W-1:0] idx;
    } scba_item_t;

endpackage

### src/scba_front.sv
module scba_front
    import scba_pkg::*;
#(
    parameter int BLOCKS_32  = 16,
    parameter int BLOCKS_64  = 16,
    parameter int BLOCKS_128 = 16,
    parameter int BLOCKS_256 = 16
)
(
    input  logic              cmd,
    input  logic [SIZE_W-1:0] req_size,
    input  logic [ADDR_W-1:0] block_addr,
    output scba_item_t        item
);

    // byte address map of the four pools
    localparam int END0_I = BLOCKS_32 * 32;
    localparam int END1_I = END0_I + BLOCKS_64 * 64;
    localparam int END2_I = END1_I + BLOCKS_128 * 128;
    localparam int END3_I = END2_I + BLOCKS_256 * 256;
    localparam logic [ADDR_W-1:0] END0 = ADDR_W'(END0_I);
    localparam logic [ADDR_W-1:0] END1 = ADDR_W'(END1_I);
    localparam logic [ADDR_W-1:0] END2 = ADDR_W'(END2_I);
    localparam logic [ADDR_W-1:0] END3 = ADDR_W'(END3_I);

    logic [ADDR_W-1:0] off;

    // classify one beat
    always_comb
    begin
        item.op   = cmd_t'(cmd);
        item.err  = ST_OK;
        item.pool = POOL_32;
        item.idx  = '0;
        off       = '0;
        if (cmd_t'(cmd) == CMD_ALLOC)
        begin
            if (req_size > CLASS3_BYTES)
                item.err = ST_TOO_LARGE;
            else if (req_size > CLASS2_BYTES)
                item.pool = POOL_256;
            else if (req_size > CLASS1_BYTES)
                item.pool = POOL_128;
            else if (req_size > CLASS0_BYTES)
                item.pool = POOL_64;
            else
                item.pool = POOL_32;
        end
        else
        begin
            // pool by address range, block index by dropping offset bits
            if (block_addr < END0)
            begin
                off       = block_addr;
                item.pool = POOL_32;
                item.idx  = off[12:5];
            end
            else if (block_addr < END1)
            begin
                off       = block_addr - END0;
                item.pool = POOL_64;
                item.idx  = off[13:6];
            end
            else if (block_addr < END2)
            begin
                off       = block_addr - END1;
                item.pool = POOL_128;
                item.idx  = off[14:7];
            end
            else if (block_addr < END3)
            begin
                off       = block_addr - END2;
                item.pool = POOL_256;
                item.idx  = off[15:8];
            end
            else
            begin
                item.err = ST_BAD_ADDR;
            end
        end
    end

endmodule

### src/scba_queue.sv
module scba_queue
    import scba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  scba_item_t push_item,
    input  logic       pop,
    output logic       not_empty,
    output logic       full,
    output scba_item_t head_item
);

    scba_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign not_empty = (fill_reg != 2'd0);
    assign full      = (fill_reg == 2'd2);
    assign head_item = slot_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### src/scba_back.sv
module scba_back
    import scba_pkg::*;
#(
    parameter int BLOCKS_32  = 16,
    parameter int BLOCKS_64  = 16,
    parameter int BLOCKS_128 = 16,
    parameter int BLOCKS_256 = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  scba_item_t        item,
    output logic              item_pop,
    output logic              sweeping,
    output logic              done,
    output logic [2:0]        status,
    output logic [ADDR_W-1:0] grant_addr,
    output logic [1:0]        pool_id,
    output logic [CNT_W-1:0]  free_left
);

    localparam int TOTAL   = BLOCKS_32 + BLOCKS_64 + BLOCKS_128 + BLOCKS_256;
    localparam int LINK_AW = $clog2(TOTAL);
    localparam int ABASE1  = BLOCKS_32 * 32;
    localparam int ABASE2  = ABASE1 + BLOCKS_64 * 64;
    localparam int ABASE3  = ABASE2 + BLOCKS_128 * 128;

    // per pool constants
    function automatic logic [CNT_W-1:0] pool_blocks(input logic [1:0] p);
        logic [CNT_W-1:0] n;
        unique case (p)
            POOL_32:  n = CNT_W'(BLOCKS_32);
            POOL_64:  n = CNT_W'(BLOCKS_64);
            POOL_128: n = CNT_W'(BLOCKS_128);
            default:  n = CNT_W'(BLOCKS_256);
        endcase
        return n;
    endfunction

    function automatic logic [LINK_AW-1:0] link_base(input logic [1:0] p);
        logic [LINK_AW-1:0] b;
        unique case (p)
            POOL_32:  b = '0;
            POOL_64:  b = LINK_AW'(BLOCKS_32);
            POOL_128: b = LINK_AW'(BLOCKS_32 + BLOCKS_64);
            default:  b = LINK_AW'(BLOCKS_32 + BLOCKS_64 + BLOCKS_128);
        endcase
        return b;
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr_of(input logic [1:0] p,
                                                        input logic [IDX_W-1:0] h);
        logic [ADDR_W-1:0] a;
        unique case (p)
            POOL_32:  a = ADDR_W'({h, 5'b0});
            POOL_64:  a = ADDR_W'(ABASE1) + ADDR_W'({h, 6'b0});
            POOL_128: a = ADDR_W'(ABASE2) + ADDR_W'({h, 7'b0});
            default:  a = ADDR_W'(ABASE3) + ADDR_W'({h, 8'b0});
        endcase
        return a;
    endfunction

    bk_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   head_reg [4];
    logic [IDX_W-1:0]   head_next [4];
    logic [CNT_W-1:0]   count_reg [4];
    logic [CNT_W-1:0]   count_next [4];
    logic [1:0]         pend_pool_reg, pend_pool_next;
    logic [LINK_AW-1:0] sweep_slot_reg, sweep_slot_next;
    logic [1:0]         sweep_pool_reg, sweep_pool_next;
    logic [IDX_W-1:0]   sweep_local_reg, sweep_local_next;
    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [ADDR_W-1:0]  grant_reg, grant_next;
    logic [1:0]         pool_reg, pool_next;
    logic [CNT_W-1:0]   left_reg, left_next;

    // link memory
    logic [IDX_W-1:0]   link_mem [TOTAL];
    logic [IDX_W-1:0]   rdata_reg;
    logic               mem_we, mem_re;
    logic [LINK_AW-1:0] mem_waddr, mem_raddr;
    logic [IDX_W-1:0]   mem_wdata;
    logic               sweep_last;
    logic [IDX_W:0]     sweep_succ;

    assign sweeping   = (state_reg == BK_INIT);
    assign done       = done_reg;
    assign status     = status_reg;
    assign grant_addr = grant_reg;
    assign pool_id    = pool_reg;
    assign free_left  = left_reg;

    // sequencer: sweep, dispatch, pop completion
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        pend_pool_next   = pend_pool_reg;
        sweep_slot_next  = sweep_slot_reg;
        sweep_pool_next  = sweep_pool_reg;
        sweep_local_next = sweep_local_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        grant_next       = grant_reg;
        pool_next        = pool_reg;
        left_next        = left_reg;
        item_pop         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = sweep_slot_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = '0;
        sweep_succ       = {1'b0, sweep_local_reg} + 1'b1;
        sweep_last       = (CNT_W'(sweep_succ) == pool_blocks(sweep_pool_reg));

        unique case (state_reg)
            BK_INIT:
            begin
                // each block links to the next, the last one to zero
                mem_we    = 1'b1;
                mem_wdata = sweep_last ? '0 : sweep_succ[IDX_W-1:0];
                sweep_slot_next = sweep_slot_reg + 1'b1;
                if (sweep_last)
                begin
                    sweep_local_next = '0;
                    sweep_pool_next  = sweep_pool_reg + 1'b1;
                    if (sweep_pool_reg == POOL_256)
                        state_next = BK_IDLE;
                end
                else
                begin
                    sweep_local_next = sweep_succ[IDX_W-1:0];
                end
            end
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop    = 1'b1;
                    grant_next  = '0;
                    pool_next   = item.pool;
                    left_next   = '0;
                    status_next = ST_OK;
                    if (item.err != ST_OK)
                    begin
                        done_next   = 1'b1;
                        status_next = item.err;
                        pool_next   = POOL_32;
                    end
                    else if (item.op == CMD_ALLOC)
                    begin
                        if (count_reg[item.pool] == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NO_FREE;
                        end
                        else
                        begin
                            // fetch the head's link, finish next cycle
                            mem_re         = 1'b1;
                            mem_raddr      = link_base(item.pool)
                                           + LINK_AW'(head_reg[item.pool]);
                            pend_pool_next = item.pool;
                            state_next     = BK_POP;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                        if (count_reg[item.pool] >= pool_blocks(item.pool))
                        begin
                            status_next = ST_POOL_FULL;
                            left_next   = count_reg[item.pool];
                        end
                        else
                        begin
                            // push: freed block points at the old head
                            mem_we                = 1'b1;
                            mem_waddr             = link_base(item.pool)
                                                  + LINK_AW'(item.idx);
                            mem_wdata             = head_reg[item.pool];
                            head_next[item.pool]  = item.idx;
                            count_next[item.pool] = count_reg[item.pool] + 1'b1;
                            left_next             = count_reg[item.pool] + 1'b1;
                        end
                    end
                end
            end
            BK_POP:
            begin
                done_next                = 1'b1;
                status_next              = ST_OK;
                pool_next                = pend_pool_reg;
                grant_next               = block_addr_of(pend_pool_reg,
                                                         head_reg[pend_pool_reg]);
                head_next[pend_pool_reg] = rdata_reg;
                count_next[pend_pool_reg] = count_reg[pend_pool_reg] - 1'b1;
                left_next                = count_reg[pend_pool_reg] - 1'b1;
                state_next               = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_INIT;
            sweep_slot_reg  <= '0;
            sweep_pool_reg  <= POOL_32;
            sweep_local_reg <= '0;
            pend_pool_reg   <= POOL_32;
            done_reg        <= 1'b0;
            for (int p = 0; p < 4; p++)
            begin
                head_reg[p]  <= '0;
                count_reg[p] <= pool_blocks(2'(p));
            end
        end
        else
        begin
            state_reg       <= state_next;
            sweep_slot_reg  <= sweep_slot_next;
            sweep_pool_reg  <= sweep_pool_next;
            sweep_local_reg <= sweep_local_next;
            pend_pool_reg   <= pend_pool_next;
            done_reg        <= done_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        grant_reg  <= grant_next;
        pool_reg   <= pool_next;
        left_reg   <= left_next;
    end

    // link memory ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= link_mem[mem_raddr];
    end

endmodule

### src/size_class_block_allocator_core.sv
// channel  | handshake             | ports
// ---------+-----------------------+---------------------------------------------
// request  | start && !busy        | cmd, req_size, block_addr
// result   | done, one cycle each  | status, grant_addr, pool_id, free_left
//
// a served allocate reads the head's link in BK_IDLE, then updates the pool in BK_POP;
// a free or any error result is settled in BK_IDLE alone.
// a two-beat queue parts classifier and back end; busy is high while it is full.
// a request waits in the queue behind any beats queued before it.
// after reset a link sweep over every block of the four pools keeps busy high.
// results cannot be held off; done marks each beat for one cycle.
module size_class_block_allocator_core
    import scba_pkg::*;
#(
    parameter int BLOCKS_32  = 16,
    parameter int BLOCKS_64  = 16,
    parameter int BLOCKS_128 = 16,
    parameter int BLOCKS_256 = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [SIZE_W-1:0] req_size,
    input  logic [ADDR_W-1:0] block_addr,
    output logic              done,
    output logic [2:0]        status,
    output logic [ADDR_W-1:0] grant_addr,
    output logic [1:0]        pool_id,
    output logic [CNT_W-1:0]  free_left
);

    scba_item_t front_item;
    scba_item_t queue_item;
    logic       accept;
    logic       queue_valid;
    logic       queue_full;
    logic       queue_pop;
    logic       sweeping;

    assign busy   = queue_full || sweeping;
    assign accept = start && !busy;

    // request classifier
    scba_front #(
        .BLOCKS_32  (BLOCKS_32),
        .BLOCKS_64  (BLOCKS_64),
        .BLOCKS_128 (BLOCKS_128),
        .BLOCKS_256 (BLOCKS_256)
    ) u_front (
        .cmd        (cmd),
        .req_size   (req_size),
        .block_addr (block_addr),
        .item       (front_item)
    );

    // decoupling queue
    scba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .full      (queue_full),
        .head_item (queue_item)
    );

    // free list engine
    scba_back #(
        .BLOCKS_32  (BLOCKS_32),
        .BLOCKS_64  (BLOCKS_64),
        .BLOCKS_128 (BLOCKS_128),
        .BLOCKS_256 (BLOCKS_256)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .sweeping   (sweeping),
        .done       (done),
        .status     (status),
        .grant_addr (grant_addr),
        .pool_id    (pool_id),
        .free_left  (free_left)
    );

    // a grant address only comes with a successful allocate
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (grant_addr == '0))
        else $error("grant address set on a failed request");

    // errors that touch no pool report pool 0 and nothing left
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && ((status == ST_TOO_LARGE) || (status == ST_BAD_ADDR))
        |-> (pool_id == POOL_32) && (free_left == '0))
        else $error("error result carries pool fields");

    // an empty pool reports zero blocks left
    a_empty_left: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_NO_FREE) |-> (free_left == '0))
        else $error("no-free result with blocks left");

    // no result while the link memory sweep runs
    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sweeping |=> !done)
        else $error("result during link sweep");

endmodule
